// ===== rtl/kab_pkg.sv =====
// Shared types and constants for the k-th ancestor block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package kab_pkg;

    localparam int NODE_W  = 10;            // node number field
    localparam int K_W     = 10;            // levels_up field
    localparam int ENTRY_W = NODE_W + 1;    // jump table entry: valid + node

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RB_BELOW,
        S_RB_CHECK,
        S_RB_MID,
        S_Q_SCAN,
        S_Q_WAIT,
        S_HIT,
        S_MISS
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_CAPTURE,
        DP_RB_BELOW,
        DP_RB_MID,
        DP_RB_ZERO,
        DP_RB_COPY,
        DP_Q_READ,
        DP_Q_SKIP,
        DP_Q_TAKE,
        DP_RES_HIT,
        DP_RES_MISS
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_cmd;

    typedef struct packed {
        logic clear_last;   // clearing pass at last address
        logic rb_last;      // rebuild at last node of last level
        logic rd_valid;     // registered table read holds a valid entry
        logic node_bad;     // input beat node out of range
        logic has_upper;    // table has levels above the parent level
        logic q_bad;        // captured query cannot have an ancestor
        logic k_zero;       // no climb bits left
        logic k_bit;        // current climb bit
        logic out_busy;     // result slot full and stalled
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/kab_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kab_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/kab_ctrl.sv =====
// Controller state machine: clearing pass, loads, table rebuild, climb, result.
// Depends on kab_pkg; drives the datapath through t_cmd, reads t_status.
`default_nettype none

module kab_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_operation,
    output logic                  o_stall,
    input  wire kab_pkg::t_status i_status,
    output kab_pkg::t_cmd         o_cmd
);
    import kab_pkg::*;

    t_state r_state, n_state;
    logic   r_stale, n_stale;
    logic   take;

    assign take = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_stale <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stale <= n_stale;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_stale = r_stale;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (take) begin
                    if (i_operation == OP_LOAD) begin
                        if (!i_status.node_bad) n_stale = 1'b1;
                    end else begin
                        n_stale = 1'b0;
                        n_state = (r_stale && i_status.has_upper) ? S_RB_BELOW : S_Q_SCAN;
                    end
                end
            end
            S_RB_BELOW: n_state = S_RB_CHECK;
            S_RB_CHECK: begin
                if (i_status.rd_valid) n_state = S_RB_MID;
                else n_state = i_status.rb_last ? S_Q_SCAN : S_RB_BELOW;
            end
            S_RB_MID: n_state = i_status.rb_last ? S_Q_SCAN : S_RB_BELOW;
            S_Q_SCAN: begin
                if (i_status.q_bad)       n_state = S_MISS;
                else if (i_status.k_zero) n_state = S_HIT;
                else if (i_status.k_bit)  n_state = S_Q_WAIT;
            end
            S_Q_WAIT: n_state = i_status.rd_valid ? S_Q_SCAN : S_MISS;
            S_HIT, S_MISS: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd.op = DP_NOP;
        case (r_state)
            S_CLEAR: o_cmd.op = DP_CLEAR;
            S_IDLE: begin
                if (take) begin
                    if (i_operation == OP_QUERY)   o_cmd.op = DP_CAPTURE;
                    else if (!i_status.node_bad) o_cmd.op = DP_LOAD;
                end
            end
            S_RB_BELOW: o_cmd.op = DP_RB_BELOW;
            S_RB_CHECK: o_cmd.op = i_status.rd_valid ? DP_RB_MID : DP_RB_ZERO;
            S_RB_MID:   o_cmd.op = DP_RB_COPY;
            S_Q_SCAN: begin
                if (!i_status.q_bad && !i_status.k_zero)
                    o_cmd.op = i_status.k_bit ? DP_Q_READ : DP_Q_SKIP;
            end
            S_Q_WAIT: begin
                if (i_status.rd_valid) o_cmd.op = DP_Q_TAKE;
            end
            S_HIT: begin
                if (!i_status.out_busy) o_cmd.op = DP_RES_HIT;
            end
            S_MISS: begin
                if (!i_status.out_busy) o_cmd.op = DP_RES_MISS;
            end
            default: o_cmd.op = DP_NOP;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    a_rebuild_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_operation == OP_QUERY && r_stale && i_status.has_upper)
            |=> r_state == S_RB_BELOW)
        else $error("stale table not rebuilt before query");

    a_fresh_climb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_SCAN || r_state == S_Q_WAIT) |-> !r_stale)
        else $error("climb on stale table");

    a_wait_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_Q_WAIT |-> $past(r_state) == S_Q_SCAN)
        else $error("table wait without issued read");

endmodule

`default_nettype wire

// ===== rtl/kab_dp.sv =====
// Datapath: one jump table RAM per level, counters, climb registers, result slot.
// Depends on kab_pkg and kab_ram; commanded by kab_ctrl.
`default_nettype none

module kab_dp #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [kab_pkg::NODE_W-1:0]  i_node,
    input  wire logic [kab_pkg::NODE_W-1:0]  i_parent,
    input  wire logic                        i_is_root,
    input  wire logic [kab_pkg::K_W-1:0]     i_levels_up,
    input  wire logic                        i_stall,
    input  wire kab_pkg::t_cmd               i_cmd,
    output kab_pkg::t_status                 o_status,
    output logic                             o_valid,
    output logic                             o_found,
    output logic [kab_pkg::NODE_W-1:0]       o_ancestor
);
    import kab_pkg::*;

    // nodes past the field range can never be loaded, so the table stops there
    localparam int LIVE = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
    localparam int AW   = $clog2(LIVE);
    localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic [AW-1:0]      r_v;      // node sweep (clear, rebuild)
    logic [LW-1:0]      r_lvl;    // rebuild source level / climb level
    logic [AW-1:0]      r_cur;
    logic [K_W-1:0]     r_k;
    logic               r_qbad;
    logic               r_out_valid;
    logic               r_found;
    logic [NODE_W-1:0]  r_ancestor;

    logic [LEVELS-1:0]  we;
    logic [AW-1:0]      waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic [ENTRY_W-1:0] rd_all [LEVELS];
    logic [ENTRY_W-1:0] rd;
    logic [LW-1:0]      wr_lvl;
    logic               v_last;
    logic               lvl_last;
    logic               node_bad;
    logic               parent_ok;
    logic               out_busy;
    logic               res_wr;

    function automatic logic k_too_high(input logic [K_W-1:0] k);
        logic bad;
        bad = 1'b0;
        for (int b = 0; b < K_W; b++) begin
            if (b >= LEVELS && k[b]) bad = 1'b1;
        end
        return bad;
    endfunction

    assign node_bad  = ({1'b0, i_node} >= (NODE_W + 1)'(LIVE));
    assign parent_ok = !i_is_root && ({1'b0, i_parent} < (NODE_W + 1)'(LIVE));
    assign rd        = rd_all[r_lvl];
    assign wr_lvl    = r_lvl + LW'(1);
    assign v_last    = (r_v == AW'(LIVE - 1));
    assign lvl_last  = (r_lvl == LW'(LEVELS - 2));
    assign out_busy  = r_out_valid && i_stall;
    assign res_wr    = (i_cmd.op == DP_RES_HIT) || (i_cmd.op == DP_RES_MISS);

    // table write port, shared address and data across levels
    always_comb begin
        we    = '0;
        waddr = r_v;
        wdata = '0;
        case (i_cmd.op)
            DP_CLEAR: we = '1;
            DP_LOAD: begin
                we    = LEVELS'(1);
                waddr = AW'(i_node);
                wdata = parent_ok ? {1'b1, i_parent} : '0;
            end
            DP_RB_ZERO: we = LEVELS'(1) << wr_lvl;
            DP_RB_COPY: begin
                we    = LEVELS'(1) << wr_lvl;
                wdata = rd;
            end
            default: we = '0;
        endcase
    end

    // table read address
    always_comb begin
        case (i_cmd.op)
            DP_RB_MID: raddr = AW'(rd[NODE_W-1:0]);
            DP_Q_READ: raddr = r_cur;
            default:   raddr = r_v;
        endcase
    end

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        kab_ram #(
            .WIDTH(ENTRY_W),
            .DEPTH(LIVE)
        ) u_ram (
            .i_clk  (i_clk),
            .i_we   (we[l]),
            .i_waddr(waddr),
            .i_wdata(wdata),
            .i_raddr(raddr),
            .o_rdata(rd_all[l])
        );
    end

    // counters and result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_CLEAR:   r_v <= v_last ? '0 : r_v + AW'(1);
                DP_CAPTURE: begin
                    r_v   <= '0;
                    r_lvl <= '0;
                end
                DP_RB_ZERO, DP_RB_COPY: begin
                    r_v <= v_last ? '0 : r_v + AW'(1);
                    if (v_last) r_lvl <= lvl_last ? '0 : r_lvl + LW'(1);
                end
                DP_Q_SKIP, DP_Q_TAKE: r_lvl <= r_lvl + LW'(1);
                default: r_lvl <= r_lvl;
            endcase
            if (res_wr)        r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    // climb and result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_CAPTURE: begin
                r_cur  <= AW'(i_node);
                r_k    <= i_levels_up;
                r_qbad <= node_bad || k_too_high(i_levels_up);
            end
            DP_Q_SKIP: r_k <= r_k >> 1;
            DP_Q_TAKE: begin
                r_cur <= AW'(rd[NODE_W-1:0]);
                r_k   <= r_k >> 1;
            end
            DP_RES_HIT: begin
                r_found    <= 1'b1;
                r_ancestor <= NODE_W'(r_cur);
            end
            DP_RES_MISS: begin
                r_found    <= 1'b0;
                r_ancestor <= '0;
            end
            default: r_cur <= r_cur;
        endcase
    end

    always_comb begin
        o_status.clear_last = v_last;
        o_status.rb_last    = v_last && lvl_last;
        o_status.rd_valid   = rd[ENTRY_W-1];
        o_status.node_bad   = node_bad;
        o_status.has_upper  = (LEVELS > 1);
        o_status.q_bad      = r_qbad;
        o_status.k_zero     = (r_k == '0);
        o_status.k_bit      = r_k[0];
        o_status.out_busy   = out_busy;
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_found;
    assign o_ancestor = r_ancestor;

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_wr |-> !out_busy)
        else $error("result written over a waiting beat");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.op == DP_RES_MISS) |-> (!r_found && r_ancestor == '0))
        else $error("missing ancestor not reported as zero");

endmodule

`default_nettype wire

// ===== rtl/kth_ancestor_binary_lifting_top.sv =====
// K-th ancestor by binary lifting. A load writes level 0 from the input beat. A query
// scans levels_up from bit 0 up to its highest set bit, with one table read per set bit.
// A query after loads first rebuilds levels 1..LEVELS-1, node by node and level by
// level, from one read port of the level RAM below. Reset (synchronous, active low)
// starts a clearing pass over min(NODES,1024) addresses; input stall is held through it.
// Depends on kab_pkg, kab_ctrl, kab_dp, kab_ram.
`default_nettype none

module kth_ancestor_binary_lifting_top #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_operation,
    input  wire logic [9:0]  i_node,
    input  wire logic [9:0]  i_parent,
    input  wire logic        i_is_root,
    input  wire logic [9:0]  i_levels_up,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_found,
    output logic [9:0]       o_ancestor
);
    import kab_pkg::*;

    // controller <-> datapath
    t_cmd    cmd;
    t_status status;

    // The controller owns sequencing and the stale flag; a beat is taken only
    // in idle. Loads write level 0 straight from the input beat.
    kab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_operation(i_operation),
        .o_stall    (o_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds one RAM per level, so the clearing pass covers all
    // levels at once, and a level rebuild reads the level below while writing
    // its own. The result slot lets a new beat in while a result waits.
    kab_dp #(
        .NODES (NODES),
        .LEVELS(LEVELS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_node     (i_node),
        .i_parent   (i_parent),
        .i_is_root  (i_is_root),
        .i_levels_up(i_levels_up),
        .i_stall    (i_stall),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_found    (o_found),
        .o_ancestor (o_ancestor)
    );

endmodule

`default_nettype wire
